// ----- hw/rtl/fpa_pkg.sv -----
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the Q24.8 fixed-point ALU: word widths,
// opcodes and the records that travel down the pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

	// Word layout
	localparam int WORD_W = 32;
	localparam int FRAC_W = 8;
	localparam int NUM_W = WORD_W + FRAC_W;

	// Divider: restoring division, DIV_STEPS quotient bits per stage
	localparam int DIV_STEPS = 4;
	localparam int DIV_STAGES = NUM_W / DIV_STEPS;

	// Rounding bias that turns a floor shift into truncation toward zero
	localparam logic [WORD_W-1:0] TRUNC_BIAS = {{(WORD_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}};

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_TO_INT   = 4'd14,
		OP_FROM_INT = 4'd15
	} op_t;

	// Entry stage: operands, early result and divider operands
	typedef struct packed {
		op_t               func;
		word_t             a;
		word_t             b;
		word_t             res;
		logic              cmp;
		logic              dz;
		logic              qneg;
		logic [NUM_W-1:0]  nmag;
		logic [WORD_W-1:0] dmag;
	} ent_t;

	// Divider stages: result so far plus partial remainder and quotient
	typedef struct packed {
		op_t               func;
		word_t             res;
		logic              cmp;
		logic              dz;
		logic              qneg;
		logic [WORD_W-1:0] rem;
		logic [NUM_W-1:0]  num;
		logic [WORD_W-1:0] den;
	} pipe_t;

	// Output stage
	typedef struct packed {
		op_t   func;
		word_t res;
		logic  cmp;
		logic  dz;
	} tail_t;

endpackage

// ----- hw/rtl/fpa_if.sv -----
// ----------------------------------------------------------------------------
// fpa_cmd_if / fpa_rsp_if
// Valid/ready channels of the fixed-point ALU: command words in, result
// words out. A word moves at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface fpa_cmd_if import fpa_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [3:0]  func;
	word_t       operand_a;
	word_t       operand_b;

	modport source (output valid, output func, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input func, input operand_a, input operand_b,
		output ready);
endinterface

interface fpa_rsp_if import fpa_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t result_raw;
	logic  compare_true;
	logic  divide_by_zero;

	modport source (output valid, output result_raw, output compare_true,
		output divide_by_zero, input ready);
	modport sink (input valid, input result_raw, input compare_true,
		input divide_by_zero, output ready);
endinterface

// ----- hw/rtl/fixed_point_alu_q24_8.sv -----
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed Q24.8 fixed-point ALU: add, subtract, multiply, divide, compares,
// min/max, increment/decrement and integer conversions.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries func, operand_a and operand_b; rsp returns result_raw,
//   compare_true and divide_by_zero, one result word per command word, in
//   order. Both channels move a word when valid and ready are high together.
//   Every word takes the same path: an entry stage (simple operations and
//   operand magnitudes), a multiply stage, DIV_STAGES divider stages of
//   DIV_STEPS quotient bits each, and an output stage. The entry stage loads
//   at the accepting edge; rsp.valid rises when the word is loaded into the
//   output stage.
//   Throughput is one word per cycle while rsp.ready is high; the divider
//   pipeline, 40 quotient bits at 4 bits per stage, sets the latency.
//   Each stage holds its word while the stage after it is full and stalled,
//   and empty stages close up, so cmd.ready stays high while a bubble is left
//   anywhere in the pipeline, even with a result waiting on rsp.
//   Reset clears all valid bits: the pipeline comes out empty and cmd.ready
//   is high from the first cycle.
//   Divide by zero returns 0 with divide_by_zero set; all overflow wraps.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 import fpa_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	fpa_cmd_if.sink    cmd,
	fpa_rsp_if.source  rsp
);

	// Stage valid bits, stage words and advance enables
	logic  v_s1, v_s2, v_tail;
	ent_t  ent_s1;
	pipe_t pip_s2;
	tail_t tail_s;
	logic  en_s1, en_s2, en_tail;
	logic  [DIV_STAGES:0] dgo;
	logic  [DIV_STAGES:0] dv;
	pipe_t dpipe [0:DIV_STAGES];

	ent_t  ent_d;
	pipe_t pip_d;
	tail_t tail_d;

	// Advance chain: a stage moves when empty or when the next one moves
	assign en_tail = !v_tail || rsp.ready;
	assign dgo[DIV_STAGES] = en_tail;
	assign en_s2 = !v_s2 || dgo[0];
	assign en_s1 = !v_s1 || en_s2;
	assign cmd.ready = en_s1;

	// Entry: simple operations, compares and divider operands
	always_comb begin
		word_t             a;
		word_t             b;
		op_t               op;
		logic              lt_ab;
		logic              lt_ba;
		logic              eq_ab;
		word_t             bias_sum;
		logic [WORD_W-1:0] a_mag;
		logic [WORD_W-1:0] b_mag;
		a = cmd.operand_a;
		b = cmd.operand_b;
		op = op_t'(cmd.func);
		lt_ab = a < b;
		lt_ba = b < a;
		eq_ab = a == b;
		bias_sum = a + (a[WORD_W-1] ? word_t'(TRUNC_BIAS) : word_t'(0));
		a_mag = a[WORD_W-1] ? (~a + 1'b1) : a;
		b_mag = b[WORD_W-1] ? (~b + 1'b1) : b;

		ent_d.func = op;
		ent_d.a = a;
		ent_d.b = b;
		ent_d.res = '0;
		ent_d.cmp = 1'b0;
		ent_d.dz = (op == OP_DIV) && (b == '0);
		ent_d.qneg = a[WORD_W-1] ^ b[WORD_W-1];
		ent_d.nmag = {a_mag, {FRAC_W{1'b0}}};
		ent_d.dmag = b_mag;
		case (op)
			OP_ADD:      ent_d.res = a + b;
			OP_SUB:      ent_d.res = a - b;
			OP_MUL:      ent_d.res = '0;
			OP_DIV:      ent_d.res = '0;
			OP_GT:       ent_d.cmp = lt_ba;
			OP_LT:       ent_d.cmp = lt_ab;
			OP_GE:       ent_d.cmp = !lt_ab;
			OP_LE:       ent_d.cmp = !lt_ba;
			OP_EQ:       ent_d.cmp = eq_ab;
			OP_NE:       ent_d.cmp = !eq_ab;
			OP_MIN:      ent_d.res = lt_ab ? a : b;
			OP_MAX:      ent_d.res = lt_ba ? a : b;
			OP_INC:      ent_d.res = a + word_t'(1);
			OP_DEC:      ent_d.res = a - word_t'(1);
			OP_TO_INT:   ent_d.res = bias_sum >>> FRAC_W;
			OP_FROM_INT: ent_d.res = a <<< FRAC_W;
			default:     ent_d.res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && cmd.valid) begin
			ent_s1 <= ent_d;
		end
	end

	// Multiply: full signed product, keep the word above the fraction bits
	always_comb begin
		logic signed [2*WORD_W-1:0] prod;
		prod = ent_s1.a * ent_s1.b;
		pip_d.func = ent_s1.func;
		pip_d.res = (ent_s1.func == OP_MUL) ? prod[FRAC_W+WORD_W-1:FRAC_W] : ent_s1.res;
		pip_d.cmp = ent_s1.cmp;
		pip_d.dz = ent_s1.dz;
		pip_d.qneg = ent_s1.qneg;
		pip_d.rem = '0;
		pip_d.num = ent_s1.nmag;
		pip_d.den = ent_s1.dmag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			pip_s2 <= pip_d;
		end
	end

	// Divider pipeline
	assign dpipe[0] = pip_s2;
	assign dv[0] = v_s2;

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		assign dgo[k] = !dv[k+1] || dgo[k+1];

		fpa_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (dgo[k]),
			.in_valid  (dv[k]),
			.in_word   (dpipe[k]),
			.out_valid (dv[k+1]),
			.out_word  (dpipe[k+1])
		);
	end

	// Output: apply quotient sign, force zero on divide by zero
	always_comb begin
		logic [WORD_W-1:0] q;
		q = dpipe[DIV_STAGES].num[WORD_W-1:0];
		tail_d.func = dpipe[DIV_STAGES].func;
		tail_d.cmp = dpipe[DIV_STAGES].cmp;
		tail_d.dz = dpipe[DIV_STAGES].dz;
		tail_d.res = dpipe[DIV_STAGES].res;
		if (dpipe[DIV_STAGES].func == OP_DIV) begin
			if (dpipe[DIV_STAGES].dz) begin
				tail_d.res = '0;
			end else if (dpipe[DIV_STAGES].qneg) begin
				tail_d.res = ~q + 1'b1;
			end else begin
				tail_d.res = q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_tail <= 1'b0;
		end else if (en_tail) begin
			v_tail <= dv[DIV_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en_tail && dv[DIV_STAGES]) begin
			tail_s <= tail_d;
		end
	end

	assign rsp.valid = v_tail;
	assign rsp.result_raw = tail_s.res;
	assign rsp.compare_true = tail_s.cmp;
	assign rsp.divide_by_zero = tail_s.dz;

`ifndef SYNTHESIS
	// Divide by zero only on a divide, and then the result is zero
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_tail && tail_s.dz |-> tail_s.func == OP_DIV && tail_s.res == '0)
		else $error("divide_by_zero set with a nonzero result or on another op");

	// Compare flag only on compare opcodes
	a_cmp_op: assert property (@(posedge clk) disable iff (!arst_n)
		v_tail && tail_s.cmp |-> tail_s.func == OP_GT || tail_s.func == OP_LT ||
			tail_s.func == OP_GE || tail_s.func == OP_LE ||
			tail_s.func == OP_EQ || tail_s.func == OP_NE)
		else $error("compare_true set on a non-compare op");

	// An accepted command word lands in the entry stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> v_s1)
		else $error("accepted command word lost at entry");

	// A stalled output word holds in the output stage
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_tail && !rsp.ready |=> v_tail && $stable(tail_s))
		else $error("stalled result word changed or dropped");

	// Input backpressure only when the entry, multiply and output stages are full and rsp is stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> v_s1 && v_s2 && v_tail && !rsp.ready)
		else $error("command channel stalled with a bubble in the pipeline");
`endif

endmodule

// ----- hw/rtl/fpa_div_stage.sv -----
// ----------------------------------------------------------------------------
// fpa_div_stage
// One register stage of the restoring divider: develops DIV_STEPS quotient
// bits and passes the rest of the word along untouched.
// ----------------------------------------------------------------------------
module fpa_div_stage import fpa_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  pipe_t in_word,
	output logic  out_valid,
	output pipe_t out_word
);

	logic  valid_s;
	pipe_t word_s;
	pipe_t step_word;

	// Shift in one numerator bit per step, subtract the divisor when it fits
	always_comb begin
		logic [WORD_W:0]   rem_sh;
		logic [WORD_W:0]   diff;
		logic [WORD_W-1:0] rem;
		logic [NUM_W-1:0]  num;
		step_word = in_word;
		rem = in_word.rem;
		num = in_word.num;
		for (int i = 0; i < DIV_STEPS; i++) begin
			rem_sh = {rem, num[NUM_W-1]};
			diff = rem_sh - {1'b0, in_word.den};
			num = {num[NUM_W-2:0], 1'b0};
			if (!diff[WORD_W]) begin
				rem = diff[WORD_W-1:0];
				num[0] = 1'b1;
			end else begin
				rem = rem_sh[WORD_W-1:0];
			end
		end
		step_word.rem = rem;
		step_word.num = num;
	end

	// Advance the stage when the next one can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (en) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			word_s <= step_word;
		end
	end

	assign out_valid = valid_s;
	assign out_word = word_s;

endmodule
